// ===== design/genome_graph_to_chromosomes_macros.svh =====
// Assertion macros shared by the genome graph to chromosomes RTL.
// Include by bare file name; every macro samples on the rising edge of clock.
`ifndef GENOME_GRAPH_TO_CHROMOSOMES_MACROS_SVH
`define GENOME_GRAPH_TO_CHROMOSOMES_MACROS_SVH

// Same-cycle implication, idle while reset is high.
`define GGC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ggc assertion failed");

// Next-cycle implication, idle while reset is high.
`define GGC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ggc assertion failed");

`endif

// ===== design/ggc_pkg.sv =====
// Shared types, constants and a helper function for the genome graph to chromosomes block.
// No dependencies; used by the datapath, the controller and the top level.
`default_nettype none

package ggc_pkg;

   localparam int NODE_COUNT     = 64;
   localparam int NODE_W         = 6;
   localparam int FIELD_W        = 7;
   localparam int BLOCK_W        = 7;
   localparam int BLOCK_LIMIT    = 32;
   localparam int BUF_AW         = 5;
   localparam int BUF_W          = BLOCK_W + 1;
   localparam int NCNT_W         = 6;
   localparam int MAX_BLOCKS_DEF = 32;

   // Controller to datapath commands.
   typedef struct packed {
      logic accept;
      logic load_b;
      logic init;
      logic start;
      logic next;
      logic emit_ld;
      logic err_ld;
      logic clear;
   } ggc_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic item_ok;
      logic edge_last;
      logic last_in;
      logic bad;
      logic s_done;
      logic n_zero;
      logic seen;
      logic step_fail;
      logic closed;
      logic emit_last;
      logic out_free;
   } ggc_sts_type;

   // Zero-based node v is node number v+1: odd numbers give a negative block.
   function automatic logic [BLOCK_W-1:0] block_of(input logic [NODE_W-1:0] v);
      logic [BLOCK_W-1:0] blk;
      blk = {2'b00, v[NODE_W-1:1]} + BLOCK_W'(1);
      if (!v[0]) begin
         blk = ~blk + BLOCK_W'(1);
      end
      return blk;
   endfunction

endpackage

`default_nettype wire

// ===== design/ggc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module ggc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/ggc_datapath.sv =====
// Datapath: edge capture, neighbour, start-node and result memories, walk registers,
// visited and written maps, output register. Uses ggc_pkg, ggc_ram, the macros header.
`default_nettype none
`include "genome_graph_to_chromosomes_macros.svh"

module ggc_datapath #(
   parameter int MAX_BLOCKS = ggc_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ggc_pkg::FIELD_W-1:0]   node_from,
   input  wire logic [ggc_pkg::FIELD_W-1:0]   node_to,
   input  wire logic                          last_edge,
   input  wire ggc_pkg::ggc_cmd_type          cmd,
   output ggc_pkg::ggc_sts_type               sts,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [ggc_pkg::BLOCK_W-1:0]        rsp_block,
   output logic                               rsp_chrom_end,
   output logic                               rsp_last,
   output logic                               rsp_error
);
   import ggc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int SIDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CMP_W  = (CNT_W > NCNT_W) ? CNT_W : NCNT_W;

   logic [NODE_W-1:0]  from_ff, from_in;
   logic [NODE_W-1:0]  to_ff, to_in;
   logic               last_ff, last_in;
   logic               bad_ff, bad_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   s_ff, s_in;
   logic [NCNT_W-1:0]  n_ff, n_in;
   logic [NCNT_W-1:0]  i_ff, i_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic [NODE_W-1:0]  close_ff, close_in;
   logic [NODE_COUNT-1:0] visited_ff, visited_in;
   logic [NODE_COUNT-1:0] written_ff, written_in;
   logic               out_valid_ff, out_valid_in;
   logic [BLOCK_W-1:0] out_block_ff, out_block_in;
   logic               out_chrom_ff, out_chrom_in;
   logic               out_last_ff, out_last_in;
   logic               out_error_ff, out_error_in;

   logic               from_ok, to_ok;
   logic [NODE_W-1:0]  a_node, b_node;
   logic [CMP_W-1:0]   limit;
   logic               out_free;

   logic               nb_we;
   logic [NODE_W-1:0]  nb_waddr, nb_wdata, nb_rdata;
   logic [NODE_W-1:0]  st_rdata;
   logic               buf_we;
   logic [BUF_W-1:0]   buf_wdata, buf_rdata;

   assign from_ok  = (node_from != '0) && (node_from <= FIELD_W'(NODE_COUNT));
   assign to_ok    = (node_to != '0) && (node_to <= FIELD_W'(NODE_COUNT));
   assign a_node   = NODE_W'(node_from - FIELD_W'(1));
   assign b_node   = NODE_W'(node_to - FIELD_W'(1));
   assign limit    = (CMP_W'(count_ff) > CMP_W'(BLOCK_LIMIT)) ? CMP_W'(BLOCK_LIMIT)
                                                                : CMP_W'(count_ff);
   assign out_free = !out_valid_ff || rsp_ready;

   assign sts.item_ok   = from_ok && to_ok && (count_ff < CNT_W'(MAX_BLOCKS));
   assign sts.edge_last = last_edge;
   assign sts.last_in   = last_ff;
   assign sts.bad       = bad_ff;
   assign sts.s_done    = (s_ff == count_ff);
   assign sts.n_zero    = (n_ff == '0);
   assign sts.seen      = visited_ff[st_rdata];
   assign sts.step_fail = (CMP_W'(n_ff) >= limit) || !written_ff[cur_ff];
   assign sts.closed    = (nb_rdata == close_ff);
   assign sts.emit_last = ((i_ff + NCNT_W'(1)) == n_ff);
   assign sts.out_free  = out_free;

   // Neighbour table: first direction on accept, reverse direction in the next cycle (load_b).
   assign nb_we    = (cmd.accept && sts.item_ok) || cmd.load_b;
   assign nb_waddr = cmd.load_b ? to_ff : a_node;
   assign nb_wdata = cmd.load_b ? from_ff : b_node;

   assign buf_we    = cmd.next;
   assign buf_wdata = {sts.closed, block_of(cur_ff)};

   ggc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_nb_ram (
      .clock (clock),
      .we    (nb_we),
      .waddr (nb_waddr),
      .wdata (nb_wdata),
      .raddr (cur_ff),
      .rdata (nb_rdata)
   );

   ggc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_BLOCKS)) u_start_ram (
      .clock (clock),
      .we    (cmd.accept && sts.item_ok),
      .waddr (count_ff[SIDX_W-1:0]),
      .wdata (a_node),
      .raddr (s_ff[SIDX_W-1:0]),
      .rdata (st_rdata)
   );

   ggc_ram #(.WIDTH(BUF_W), .DEPTH(BLOCK_LIMIT)) u_buf_ram (
      .clock (clock),
      .we    (buf_we),
      .waddr (n_ff[BUF_AW-1:0]),
      .wdata (buf_wdata),
      .raddr (i_ff[BUF_AW-1:0]),
      .rdata (buf_rdata)
   );

   always_comb begin
      from_in      = from_ff;
      to_in        = to_ff;
      last_in      = last_ff;
      bad_in       = bad_ff;
      count_in     = count_ff;
      s_in         = s_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      cur_in       = cur_ff;
      close_in     = close_ff;
      visited_in   = visited_ff;
      written_in   = written_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_block_in = out_block_ff;
      out_chrom_in = out_chrom_ff;
      out_last_in  = out_last_ff;
      out_error_in = out_error_ff;

      if (cmd.accept) begin
         from_in = a_node;
         to_in   = b_node;
         last_in = last_edge;
         if (sts.item_ok) begin
            written_in[a_node] = 1'b1;
            count_in           = count_ff + CNT_W'(1);
         end else begin
            bad_in = 1'b1;
         end
      end
      if (cmd.load_b) begin
         written_in[to_ff] = 1'b1;
      end
      if (cmd.init) begin
         s_in = '0;
         n_in = '0;
         i_in = '0;
      end
      if (cmd.start) begin
         s_in = s_ff + CNT_W'(1);
         if (!visited_ff[st_rdata]) begin
            visited_in[st_rdata] = 1'b1;
            cur_in               = st_rdata;
            close_in             = st_rdata ^ NODE_W'(1);
         end
      end
      if (cmd.next) begin
         n_in                 = n_ff + NCNT_W'(1);
         visited_in[nb_rdata] = 1'b1;
         if (!sts.closed) begin
            // continue from the other end of the block just reached
            cur_in                               = nb_rdata ^ NODE_W'(1);
            visited_in[nb_rdata ^ NODE_W'(1)]    = 1'b1;
         end
      end
      if (cmd.emit_ld) begin
         out_valid_in = 1'b1;
         out_block_in = buf_rdata[BLOCK_W-1:0];
         out_chrom_in = buf_rdata[BUF_W-1];
         out_last_in  = sts.emit_last;
         out_error_in = 1'b0;
         i_in         = i_ff + NCNT_W'(1);
      end
      if (cmd.err_ld) begin
         out_valid_in = 1'b1;
         out_block_in = '0;
         out_chrom_in = 1'b0;
         out_last_in  = 1'b1;
         out_error_in = 1'b1;
      end
      if (cmd.clear) begin
         bad_in     = 1'b0;
         count_in   = '0;
         visited_in = '0;
         written_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_ff       <= 1'b0;
         count_ff     <= '0;
         visited_ff   <= '0;
         written_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         bad_ff       <= bad_in;
         count_ff     <= count_in;
         visited_ff   <= visited_in;
         written_ff   <= written_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      from_ff      <= from_in;
      to_ff        <= to_in;
      last_ff      <= last_in;
      s_ff         <= s_in;
      n_ff         <= n_in;
      i_ff         <= i_in;
      cur_ff       <= cur_in;
      close_ff     <= close_in;
      out_block_ff <= out_block_in;
      out_chrom_ff <= out_chrom_in;
      out_last_ff  <= out_last_in;
      out_error_ff <= out_error_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_block     = out_block_ff;
   assign rsp_chrom_end = out_chrom_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_error     = out_error_ff;

   `GGC_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CNT_W'(MAX_BLOCKS))
   `GGC_ASSERT_NOW(a_no_overwrite, cmd.emit_ld || cmd.err_ld, !out_valid_ff || rsp_ready)
   `GGC_ASSERT_NOW(a_walk_bound, cmd.next, CMP_W'(n_ff) < limit)
   `GGC_ASSERT_NEXT(a_clear_done, cmd.clear, count_ff == '0 && !bad_ff && visited_ff == '0)

endmodule

`default_nettype wire

// ===== design/ggc_ctrl.sv =====
// Controller state machine: edge loading, cycle walk, result emission and per-set clear.
// Depends on ggc_pkg for the command and status structs.
`default_nettype none

module ggc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ggc_pkg::ggc_sts_type sts,
   output ggc_pkg::ggc_cmd_type      cmd
);
   import ggc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_B,
      ST_W_INIT,
      ST_W_FETCH,
      ST_W_START,
      ST_W_STEP,
      ST_W_NEXT,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_ERR,
      ST_CLEAR
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.item_ok) begin
                  state_in = ST_LOAD_B;
               end else if (sts.edge_last) begin
                  // a rejected edge still ends the set when it carries the last flag
                  state_in = ST_ERR;
               end
            end
         end
         ST_LOAD_B: begin
            cmd.load_b = 1'b1;
            state_in   = sts.last_in ? ST_W_INIT : ST_IDLE;
         end
         ST_W_INIT: begin
            cmd.init = 1'b1;
            state_in = sts.bad ? ST_ERR : ST_W_FETCH;
         end
         ST_W_FETCH: begin
            // start-node read is in flight for the current index
            if (sts.s_done) begin
               state_in = sts.n_zero ? ST_ERR : ST_EMIT_RD;
            end else begin
               state_in = ST_W_START;
            end
         end
         ST_W_START: begin
            cmd.start = 1'b1;
            state_in  = sts.seen ? ST_W_FETCH : ST_W_STEP;
         end
         ST_W_STEP: begin
            state_in = sts.step_fail ? ST_ERR : ST_W_NEXT;
         end
         ST_W_NEXT: begin
            cmd.next = 1'b1;
            state_in = sts.closed ? ST_W_FETCH : ST_W_STEP;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (sts.out_free) begin
               cmd.emit_ld = 1'b1;
               state_in    = sts.emit_last ? ST_CLEAR : ST_EMIT_RD;
            end
         end
         ST_ERR: begin
            if (sts.out_free) begin
               cmd.err_ld = 1'b1;
               state_in   = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/genome_graph_to_chromosomes.sv =====
// Genome graph to chromosomes, top level.
// Input channel (req_): one coloured edge per item, node_from and node_to numbered
//   from one in tdata, last_edge on tlast. Result channel (rsp_): one signed block
//   per item in tdata, chromosome end and error flags in tuser, end of answer on tlast.
// An in-range edge makes two writes to the single-write-port neighbour RAM, one per
//   direction; a rejected edge only marks the set bad, and a rejected last edge goes
//   straight to the error result. On the last edge the walk runs first: W_FETCH and
//   W_START per start node (registered start-node RAM read), then W_STEP and W_NEXT
//   per block (registered neighbour RAM read). Results are buffered and then sent,
//   each through EMIT_RD and EMIT_LD, while the receiver is ready; an error set gives
//   one result. A clear state follows, then the next edge is taken.
// Results appear only after the whole walk has closed, so an error found late
//   drops every block of that set.
// Reset (synchronous, active high) empties the per-set state and the output
//   register. A stalled receiver holds the output register; emission waits for it,
//   and input ready stays low until the set is done.
`default_nettype none

module genome_graph_to_chromosomes #(
   parameter int MAX_BLOCKS = ggc_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [6:0] node_from, [13:7] node_to, [15:14] zero
   input  wire logic        req_tlast,   // last_edge
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [6:0] block, [7] zero
   output logic [1:0]       rsp_tuser,   // [0] chromosome_end, [1] error
   output logic             rsp_tlast    // last
);
   import ggc_pkg::*;

   ggc_cmd_type        cmd;
   ggc_sts_type        sts;
   logic [BLOCK_W-1:0] blk;
   logic               chrom_end;
   logic               err;

   ggc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ggc_datapath #(.MAX_BLOCKS(MAX_BLOCKS)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .node_from     (req_tdata[6:0]),
      .node_to       (req_tdata[13:7]),
      .last_edge     (req_tlast),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_block     (blk),
      .rsp_chrom_end (chrom_end),
      .rsp_last      (rsp_tlast),
      .rsp_error     (err)
   );

   assign rsp_tdata = {1'b0, blk};
   assign rsp_tuser = {err, chrom_end};

endmodule

`default_nettype wire

// ===== verif/genome_graph_to_chromosomes_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for genome_graph_to_chromosomes: edges in, signed synteny blocks out.
// Depends on ggc_pkg and the top level; predicts blocks with its own cycle walker, typed rows carry their own.

module genome_graph_to_chromosomes_tb;
   import ggc_pkg::*;

   localparam int EDGE_CAP    = MAX_BLOCKS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int DIR_ROWS    = 23;
   localparam int RAND_ITEMS  = 60;

   typedef struct packed {
      logic signed [6:0] blk;
      logic              cend;
      logic              last;
      logic              err;
   } block_result_type;

   typedef struct packed {
      logic [6:0]        from_node;
      logic [6:0]        to_node;
      logic              last_edge;
      logic              typed;
      logic signed [6:0] blk;
      logic              cend;
      logic              err;
   } edge_row_type;

   // Rows with typed set carry their single expected block; the rest go to the predictor.
   localparam edge_row_type DIRECTED [DIR_ROWS] = '{
      '{7'd1,   7'd2,   1'b1, 1'b1, -7'sd1,  1'b1, 1'b0},   // lowest node, minus strand
      '{7'd2,   7'd1,   1'b1, 1'b1,  7'sd1,  1'b1, 1'b0},
      '{7'd64,  7'd63,  1'b1, 1'b1,  7'sd32, 1'b1, 1'b0},   // highest node
      '{7'd63,  7'd64,  1'b1, 1'b1, -7'sd32, 1'b1, 1'b0},
      '{7'd0,   7'd5,   1'b1, 1'b1,  7'sd0,  1'b0, 1'b1},   // node zero
      '{7'd5,   7'd0,   1'b1, 1'b1,  7'sd0,  1'b0, 1'b1},
      '{7'd65,  7'd3,   1'b1, 1'b1,  7'sd0,  1'b0, 1'b1},   // node above range
      '{7'd3,   7'd127, 1'b1, 1'b1,  7'sd0,  1'b0, 1'b1},
      '{7'd127, 7'd127, 1'b1, 1'b1,  7'sd0,  1'b0, 1'b1},
      '{7'd0,   7'd0,   1'b0, 1'b0,  7'sd0,  1'b0, 1'b0},   // bad edge mid-set
      '{7'd3,   7'd4,   1'b1, 1'b1,  7'sd0,  1'b0, 1'b1},   // poisons a good last edge
      '{7'd1,   7'd3,   1'b1, 1'b1,  7'sd0,  1'b0, 1'b1},   // partner never written
      '{7'd1,   7'd3,   1'b0, 1'b0,  7'sd0,  1'b0, 1'b0},
      '{7'd4,   7'd3,   1'b1, 1'b1,  7'sd0,  1'b0, 1'b1},   // walk never closes
      '{7'd2,   7'd4,   1'b0, 1'b0,  7'sd0,  1'b0, 1'b0},   // (+1 -2 -3)
      '{7'd3,   7'd6,   1'b0, 1'b0,  7'sd0,  1'b0, 1'b0},
      '{7'd5,   7'd1,   1'b1, 1'b0,  7'sd0,  1'b0, 1'b0},
      '{7'd2,   7'd4,   1'b0, 1'b0,  7'sd0,  1'b0, 1'b0},   // (+1 -2 -3)(+4 +5 -6)
      '{7'd3,   7'd6,   1'b0, 1'b0,  7'sd0,  1'b0, 1'b0},
      '{7'd5,   7'd1,   1'b0, 1'b0,  7'sd0,  1'b0, 1'b0},
      '{7'd8,   7'd9,   1'b0, 1'b0,  7'sd0,  1'b0, 1'b0},
      '{7'd10,  7'd12,  1'b0, 1'b0,  7'sd0,  1'b0, 1'b0},
      '{7'd11,  7'd7,   1'b1, 1'b0,  7'sd0,  1'b0, 1'b0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [6:0] node_from, [13:7] node_to, [15:14] zero
   logic        req_tlast;    // last_edge
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [6:0] block, [7] zero
   logic [1:0]  rsp_tuser;    // [0] chromosome_end, [1] error
   logic        rsp_tlast;    // last

   // Predictor state for the current data set.
   logic [NODE_W-1:0] nbr [NODE_COUNT];
   bit                nbr_set [NODE_COUNT];
   logic [NODE_W-1:0] starts [EDGE_CAP];
   bit                seen [NODE_COUNT];
   int                n_edges;
   bit                set_bad;
   block_result_type  walk_out [BLOCK_LIMIT];
   int                walk_n;

   block_result_type expected_blocks [$];
   block_result_type want, got;
   block_result_type no_result = '0;

   logic [6:0] e_from [40];
   logic [6:0] e_to [40];

   bit idle_on;
   bit pressure_go;
   int mismatches = 0;
   int results_seen = 0;
   int error_sets = 0;
   int edges_sent;
   int sets_sent;
   int cycle_count = 0;

   genome_graph_to_chromosomes uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic signed [6:0] block_number(input logic [NODE_W-1:0] v);
      int n;
      n = int'(v) + 1;
      return (n % 2) ? 7'(-(n + 1) / 2) : 7'(n / 2);
   endfunction

   task automatic clear_set();
      for (int i = 0; i < NODE_COUNT; i++) begin
         nbr_set[i] = 1'b0;
         seen[i] = 1'b0;
      end
      n_edges = 0;
      set_bad = 1'b0;
   endtask

   // Store one edge; on the last edge walk the cycles into walk_out.
   task automatic predict_edge(input logic [6:0] f, input logic [6:0] t, input bit l);
      logic [NODE_W-1:0] a, b, o, d, closing;
      int limit;
      bit fail;
      walk_n = 0;
      if (f < 7'd1 || f > 7'(NODE_COUNT) || t < 7'd1 || t > 7'(NODE_COUNT)) begin
         set_bad = 1'b1;
      end else if (n_edges >= EDGE_CAP) begin
         set_bad = 1'b1;
      end else begin
         a = NODE_W'(f - 7'd1);
         b = NODE_W'(t - 7'd1);
         nbr[a] = b;
         nbr[b] = a;
         nbr_set[a] = 1'b1;
         nbr_set[b] = 1'b1;
         starts[n_edges] = a;
         n_edges++;
      end
      if (!l) return;
      fail = set_bad;
      limit = (n_edges < BLOCK_LIMIT) ? n_edges : BLOCK_LIMIT;
      for (int s = 0; s < n_edges && !fail; s++) begin
         o = starts[s];
         if (!seen[o]) begin
            seen[o] = 1'b1;
            closing = o ^ NODE_W'(1);
            while (!fail) begin
               if (walk_n >= limit || !nbr_set[o]) begin
                  fail = 1'b1;
                  break;
               end
               walk_out[walk_n] = '{block_number(o), 1'b0, 1'b0, 1'b0};
               walk_n++;
               d = nbr[o];
               seen[d] = 1'b1;
               if (d == closing) begin
                  walk_out[walk_n - 1].cend = 1'b1;
                  break;
               end
               o = d ^ NODE_W'(1);
               seen[o] = 1'b1;
            end
         end
      end
      if (fail || walk_n == 0) begin
         walk_out[0] = '{7'sd0, 1'b0, 1'b1, 1'b1};
         walk_n = 1;
      end else begin
         walk_out[walk_n - 1].last = 1'b1;
      end
      clear_set();
   endtask

   // Entered at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_edge(input logic [6:0] f, input logic [6:0] t, input bit l,
                            input bit typed, input block_result_type typed_res);
      while (idle_on && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, t, f};
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      predict_edge(f, t, l);
      if (l) begin
         if (typed) begin
            expected_blocks = {expected_blocks, typed_res};
         end else begin
            for (int i = 0; i < walk_n; i++) expected_blocks = {expected_blocks, walk_out[i]};
         end
         sets_sent++;
      end
      edges_sent++;
      @(negedge clock);
   endtask

   task automatic send_edges(input int n);
      for (int i = 0; i < n; i++) send_edge(e_from[i], e_to[i], i == n - 1, 1'b0, no_result);
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      bit held;
      held = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_go && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= !idle_on || ($urandom_range(99) >= 25);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{$signed(rsp_tdata[6:0]), rsp_tuser[0], rsp_tlast, rsp_tuser[1]};
         results_seen++;
         if (got.err) error_sets++;
         if (expected_blocks.size() == 0) begin
            mismatches++;
            $display("%0t: block with none expected, actual blk=%0d end=%0b last=%0b err=%0b",
                     $time, $signed(got.blk), got.cend, got.last, got.err);
         end else begin
            want = expected_blocks.pop_front();
            if (got.blk !== want.blk || got.cend !== want.cend || got.last !== want.last ||
                got.err !== want.err) begin
               mismatches++;
               $display("%0t: expected blk=%0d end=%0b last=%0b err=%0b,",
                        $time, $signed(want.blk), want.cend, want.last, want.err,
                        " actual blk=%0d end=%0b last=%0b err=%0b",
                        $signed(got.blk), got.cend, got.last, got.err);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int ids [32];
      logic [6:0] head [32];
      logic [6:0] tail [32];
      int i, j, tmp, nblk, n_e, chr_start, set_idx, rand_items;
      logic [6:0] swap;
      edge_row_type row;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      idle_on = 1'b1;
      pressure_go = 1'b0;
      edges_sent = 0;
      sets_sent = 0;
      clear_set();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // One block per chromosome over all 64 nodes: fills the neighbour table, most blocks.
      for (i = 0; i < EDGE_CAP; i++) begin
         e_from[i] = 7'(2 * i + 1);
         e_to[i] = 7'(2 * i + 2);
      end
      send_edges(EDGE_CAP);

      for (i = 0; i < DIR_ROWS; i++) begin
         row = DIRECTED[i];
         send_edge(row.from_node, row.to_node, row.last_edge, row.typed,
                   '{row.blk, row.cend, 1'b1, row.err});
      end

      // One edge past the limit.
      e_from[EDGE_CAP] = 7'd1;
      e_to[EDGE_CAP] = 7'd2;
      send_edges(EDGE_CAP + 1);

      rand_items = 0;
      set_idx = 0;
      while (rand_items < RAND_ITEMS) begin
         idle_on = !(set_idx >= 4 && set_idx < 7);
         if (set_idx == 2) pressure_go <= 1'b1;
         tmp = $urandom_range(99);
         if (tmp < 90) begin
            for (i = 0; i < 32; i++) ids[i] = i + 1;
            for (i = 31; i > 0; i--) begin
               j = $urandom_range(i);
               tmp = ids[i];
               ids[i] = ids[j];
               ids[j] = tmp;
            end
            tmp = $urandom_range(99);
            nblk = ($urandom_range(9) == 0) ? $urandom_range(32, 16) : $urandom_range(8, 1);
            for (i = 0; i < nblk; i++) begin
               if ($urandom_range(1)) begin
                  head[i] = 7'(2 * ids[i] - 1);
                  tail[i] = 7'(2 * ids[i]);
               end else begin
                  head[i] = 7'(2 * ids[i]);
                  tail[i] = 7'(2 * ids[i] - 1);
               end
            end
            // Cut into chromosomes and join each block's tail to the next head.
            n_e = 0;
            chr_start = 0;
            for (i = 0; i < nblk; i++) begin
               if (i == nblk - 1 || $urandom_range(2) == 0) begin
                  for (j = chr_start; j <= i; j++) begin
                     e_from[n_e] = tail[j];
                     e_to[n_e] = (j == i) ? head[chr_start] : head[j + 1];
                     n_e++;
                  end
                  chr_start = i + 1;
               end
            end
            for (i = n_e - 1; i >= 0; i--) begin
               j = $urandom_range(i);
               swap = e_from[i]; e_from[i] = e_from[j]; e_from[j] = swap;
               swap = e_to[i];   e_to[i] = e_to[j];     e_to[j] = swap;
               if ($urandom_range(1)) begin
                  swap = e_from[i]; e_from[i] = e_to[i]; e_to[i] = swap;
               end
            end
            // Break a share of the well-formed sets.
            if (tmp >= 75) begin
               j = $urandom_range(n_e - 1);
               case ($urandom_range(2))
                  0: e_to[j] = 7'($urandom_range(127));
                  1: if (n_e > 1) n_e--;
                  default: begin
                     e_from[n_e] = e_from[j];
                     e_to[n_e] = e_to[j];
                     n_e++;
                  end
               endcase
            end
         end else begin
            n_e = $urandom_range(5, 1);
            for (i = 0; i < n_e; i++) begin
               e_from[i] = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                    : 7'($urandom_range(64, 1));
               e_to[i] = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                  : 7'($urandom_range(64, 1));
            end
         end
         send_edges(n_e);
         rand_items += n_e;
         set_idx++;
      end
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;

      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Run sent %0d edges in %0d data sets, full and overflowing tables, bad nodes,",
               edges_sent, sets_sent);
      $display("open walks and random genomes; %0d blocks checked, %0d error results.",
               results_seen, error_sets);
      if (mismatches == 0 && expected_blocks.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/ggc_pkg.sv
design/ggc_ram.sv
design/ggc_datapath.sv
design/ggc_ctrl.sv
design/genome_graph_to_chromosomes.sv
verif/genome_graph_to_chromosomes_tb.sv
